FILE: sv/pcxrle_pkg.sv
// Shared types and constants of the PCX run-length line encoder.
package pcxrle_pkg;

   // Base of a count byte; values at or above it cannot be sent bare.
   localparam logic [7:0] CountBase = 8'hC0;

   // Depth of the command queue between the front and the back part.
   localparam int FifoDepth = 4;
   localparam int FifoPtrW  = 2;
   localparam int FifoCntW  = 3;

   // One input request: a pixel and its end-of-line flag.
   typedef struct packed {
      logic [7:0] pixel;
      logic       end_of_line;
   } req_type;

   // One encoded result byte with its markers.
   typedef struct packed {
      logic [7:0] code_byte;
      logic       last_of_item;
      logic       line_done;
   } rsp_type;

   // One closed run to be written out.
   typedef struct packed {
      logic       valid;
      logic [7:0] value;
      logic [5:0] len;
   } run_type;

   // Work handed from the front to the back: up to two runs per request.
   typedef struct packed {
      run_type first;
      run_type second;
      logic    eol;
   } cmd_type;

endpackage

FILE: sv/pcxrle_front.sv
// Front part: tracks the open run and turns each request into run commands.
module pcxrle_front #(
   parameter int MAX_RUN = 63
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  pcxrle_pkg::req_type  req,
   output logic                 cmd_push,
   output pcxrle_pkg::cmd_type  cmd
);

   localparam logic [5:0] MaxRun = 6'(MAX_RUN);

   logic [7:0] run_value_ff, run_value_in;
   logic [5:0] run_len_ff, run_len_in;

   logic       cont;
   logic [5:0] inc_len;
   logic [7:0] mid_value;
   logic [5:0] mid_len;

   // Classify the pixel against the open run and build the commands.
   always_comb begin
      cont         = (run_len_ff != 6'd0) && (req.pixel == run_value_ff);
      inc_len      = run_len_ff + 6'd1;
      cmd          = '0;
      cmd.eol      = req.end_of_line;
      mid_value    = run_value_ff;
      mid_len      = inc_len;
      if (cont) begin
         // A run that reaches the limit is closed at once.
         if (inc_len >= MaxRun) begin
            cmd.first.valid = 1'b1;
            cmd.first.value = run_value_ff;
            cmd.first.len   = inc_len;
            mid_len         = 6'd0;
         end
      end else begin
         // A different pixel closes the open run, if any, and opens a new one.
         cmd.first.valid = (run_len_ff != 6'd0);
         cmd.first.value = run_value_ff;
         cmd.first.len   = run_len_ff;
         mid_value       = req.pixel;
         mid_len         = 6'd1;
      end
      run_value_in = mid_value;
      run_len_in   = mid_len;
      // The line's last pixel flushes what is still open.
      if (req.end_of_line) begin
         cmd.second.valid = (mid_len != 6'd0);
         cmd.second.value = mid_value;
         cmd.second.len   = mid_len;
         run_value_in     = 8'd0;
         run_len_in       = 6'd0;
      end
      cmd_push = accept && (cmd.first.valid || cmd.second.valid);
   end

   // Run state.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff <= 8'd0;
         run_len_ff   <= 6'd0;
      end else if (accept) begin
         run_value_ff <= run_value_in;
         run_len_ff   <= run_len_in;
      end
   end

endmodule

FILE: sv/pcxrle_cmd_fifo.sv
// Short command queue between the front and the back part.
module pcxrle_cmd_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pcxrle_pkg::cmd_type  push_data,
   input  logic                 pop,
   output pcxrle_pkg::cmd_type  head,
   output logic                 empty,
   output logic                 full
);

   pcxrle_pkg::cmd_type mem_ff [pcxrle_pkg::FifoDepth];

   logic [pcxrle_pkg::FifoPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pcxrle_pkg::FifoPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pcxrle_pkg::FifoCntW-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   // Status and pointer updates.
   always_comb begin
      empty     = (count_ff == '0);
      full      = (count_ff == pcxrle_pkg::FifoCntW'(pcxrle_pkg::FifoDepth));
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
      head = mem_ff[rd_ptr_ff];
   end

   // Storage of queued commands.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Queue pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: sv/pcxrle_back.sv
// Back part: expands run commands into coded bytes, one per cycle while results are taken.
module pcxrle_back (
   input  logic                 clock,
   input  logic                 reset,
   input  pcxrle_pkg::cmd_type  head,
   input  logic                 head_empty,
   output logic                 head_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output pcxrle_pkg::rsp_type  rsp_data
);

   logic [1:0]          step_ff, step_in;
   logic                out_valid_ff, out_valid_in;
   pcxrle_pkg::rsp_type out_ff, out_in;

   logic       lit_a, lit_b;
   logic [1:0] n_a, n_b;
   logic [2:0] total;
   logic       use_a;
   logic [1:0] pos;
   logic       lit_sel;
   logic [7:0] value_sel;
   logic [5:0] len_sel;
   logic [7:0] byte_sel;
   logic       last;
   logic       load;

   // Pick the byte at the current step of the head command.
   always_comb begin
      lit_a = (head.first.len == 6'd1) && (head.first.value < pcxrle_pkg::CountBase);
      lit_b = (head.second.len == 6'd1) && (head.second.value < pcxrle_pkg::CountBase);
      n_a   = head.first.valid ? (lit_a ? 2'd1 : 2'd2) : 2'd0;
      n_b   = head.second.valid ? (lit_b ? 2'd1 : 2'd2) : 2'd0;
      total = {1'b0, n_a} + {1'b0, n_b};
      use_a = (step_ff < n_a);
      pos   = use_a ? step_ff : step_ff - n_a;
      lit_sel   = use_a ? lit_a : lit_b;
      value_sel = use_a ? head.first.value : head.second.value;
      len_sel   = use_a ? head.first.len : head.second.len;
      // A run is a bare literal, or a count byte followed by the value.
      if (pos == 2'd0 && !lit_sel) begin
         byte_sel = pcxrle_pkg::CountBase + {2'b00, len_sel};
      end else begin
         byte_sel = value_sel;
      end
      last = ({1'b0, step_ff} + 3'd1 == total);
   end

   // Output register loads whenever it is free or being drained.
   always_comb begin
      load         = !head_empty && (!out_valid_ff || rsp_pop);
      head_pop     = load && last;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (load) begin
         step_in             = last ? 2'd0 : step_ff + 2'd1;
         out_valid_in        = 1'b1;
         out_in.code_byte    = byte_sel;
         out_in.last_of_item = last;
         out_in.line_done    = last && head.eol;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      rsp_empty = !out_valid_ff;
      rsp_data  = out_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

FILE: sv/pcx_rle_line_encoder_top.sv
// Top level of the PCX run-length line encoder.
// Result bytes of a request pass through the command queue, then the result register.
// One request is accepted per cycle while the command queue has room; one result byte
// leaves per cycle while results are taken, and a request yields 0 to 4 bytes.
// The single-byte output port sets the sustained rate.
// Reset is synchronous and active high; it clears the open run and empties all queues.
module pcx_rle_line_encoder_top #(
   parameter int MAX_RUN = 63
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  pcxrle_pkg::req_type  req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output pcxrle_pkg::rsp_type  rsp_data
);

   logic                cmd_push;
   pcxrle_pkg::cmd_type cmd;
   pcxrle_pkg::cmd_type head;
   logic                head_empty;
   logic                head_pop;
   logic                accept;

   assign accept = req_push && !req_full;

   // Front part: run tracking.
   pcxrle_front #(
      .MAX_RUN(MAX_RUN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .cmd_push (cmd_push),
      .cmd      (cmd)
   );

   // Command queue.
   pcxrle_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .pop       (head_pop),
      .head      (head),
      .empty     (head_empty),
      .full      (req_full)
   );

   // Back part: byte expansion and result register.
   pcxrle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_empty (head_empty),
      .head_pop   (head_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: sv/pcxrle_checker.sv
// Port-level checks of the PCX run-length line encoder.
module pcxrle_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_push,
   input logic                 req_full,
   input pcxrle_pkg::req_type  req_data,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input pcxrle_pkg::rsp_type  rsp_data
);

   // An accepted request carries a fully known pixel and flag.
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |-> !$isunknown(req_data))
      else $error("accepted request has unknown bits");

   // The last byte of a line is always the last byte of its request.
   a_line_done_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.line_done) |-> rsp_data.last_of_item)
      else $error("line_done without last_of_item");

   // A waiting result holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed");

   // Reset leaves no result waiting.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result present after reset");

   // Reset leaves room for a request.
   a_reset_room: assert property (@(posedge clock)
      reset |=> !req_full)
      else $error("input full after reset");

endmodule

bind pcx_rle_line_encoder_top pcxrle_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .req_data  (req_data),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
